### hdl/mled_pkg.sv
// shared types, constants and arithmetic helpers of the multilevel error diffusion dither
package mled_pkg;

  localparam int PIXEL_W           = 8;
  localparam int ERR_W             = 9;
  localparam int PROD_W            = 13;
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int MAX_LEVELS        = 16;
  localparam int LEVEL_SLOTS       = 16;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_W             = 12;
  localparam int QUEUE_DEPTH       = 4;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int COUNT_REG_W  = 5;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_LOW   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_HIGH  = 3'd4;

  localparam logic [WIDTH_REG_W-1:0]  RESET_IMAGE_WIDTH  = 11'd256;
  localparam logic [HEIGHT_REG_W-1:0] RESET_IMAGE_HEIGHT = 13'd256;
  localparam logic [COUNT_REG_W-1:0]  RESET_LEVEL_COUNT  = 5'd2;
  localparam logic [CFG_DATA_W-1:0]   RESET_LEVELS_LOW   = 64'h0000_0000_0000_FF00;
  localparam logic [CFG_DATA_W-1:0]   RESET_LEVELS_HIGH  = 64'h0;

  // diffusion weights in sixteenths
  localparam logic signed [4:0] W_RIGHT       = 5'sd7;
  localparam logic signed [4:0] W_BELOW_LEFT  = 5'sd3;
  localparam logic signed [4:0] W_BELOW       = 5'sd5;
  localparam logic signed [4:0] W_BELOW_RIGHT = 5'sd1;

  typedef logic [PIXEL_W-1:0]      pixel_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef struct packed {
    pixel_t pixel;
    logic   first_row;
    logic   first_col;
    logic   has_right;
    logic   row_end;
    logic   frame_end;
  } item_t;

  // weighted error divided by 16, truncated toward zero
  function automatic err_t spread(input err_t e, input logic signed [4:0] weight);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] quot;
    prod = PROD_W'(e) * PROD_W'(weight);
    if (prod < 0) begin
      quot = (prod + PROD_W'(15)) >>> 4;
    end else begin
      quot = prod >>> 4;
    end
    return ERR_W'(quot);
  endfunction

  // add a signed term to a pixel and saturate to 0..255
  function automatic pixel_t sat_add(input pixel_t v, input err_t t);
    logic signed [ERR_W+1:0] s;
    pixel_t r;
    s = $signed({{(ERR_W+2-PIXEL_W){1'b0}}, v}) + (ERR_W+2)'(t);
    if (s < 0) begin
      r = '0;
    end else if (s > (ERR_W+2)'(255)) begin
      r = '1;
    end else begin
      r = s[PIXEL_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/mled_ram.sv
// generic ram with one write port and two registered read ports
module mled_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### hdl/mled_front.sv
// front part: accepts pixels, tracks raster position and classifies each item
module mled_front #(
  parameter int MAX_WIDTH = mled_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mled_pkg::PIXEL_W-1:0]       s_tdata,   // pixel_in
  input  logic [mled_pkg::WIDTH_REG_W-1:0]   image_width,
  input  logic [mled_pkg::HEIGHT_REG_W-1:0]  image_height,
  input  logic                               queue_full,
  output logic                               push,
  output mled_pkg::item_t                    item,
  output logic [COL_W-1:0]                   item_col
);

  import mled_pkg::*;

  localparam int CW = COL_W + 1;
  localparam int RW = ROW_W + 1;

  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    width_eff;
  logic [RW-1:0]    height_eff;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (image_width == '0) begin
      width_eff = CW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      height_eff = RW'(1);
    end else if (32'(image_height) > 32'(HEIGHT_LIMIT)) begin
      height_eff = RW'(HEIGHT_LIMIT);
    end else begin
      height_eff = RW'(image_height);
    end
  end

  assign last_col = ({1'b0, column} + CW'(1)) >= width_eff;
  assign last_row = ({1'b0, row} + RW'(1)) >= height_eff;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  assign item.pixel     = s_tdata;
  assign item.first_row = (row == '0);
  assign item.first_col = (column == '0);
  assign item.has_right = !last_col;
  assign item.row_end   = last_col;
  assign item.frame_end = last_col && last_row;
  assign item_col       = column;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (push) begin
      if (last_col) begin
        column <= '0;
        row    <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

endmodule

### hdl/mled_queue.sv
// short queue between the front and back parts
module mled_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mled_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(DEPTH));
  assign empty     = (count == '0);
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

### hdl/mled_back.sv
// back part: error store, neighbour corrections, nearest level search and output register
module mled_back #(
  parameter int MAX_WIDTH = mled_pkg::DEFAULT_MAX_WIDTH,
  parameter int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  mled_pkg::item_t                   head_item,
  input  logic [COL_W-1:0]                  head_col,
  output logic                              pop,
  input  logic [mled_pkg::COUNT_REG_W-1:0]  level_count,
  input  logic [mled_pkg::CFG_DATA_W-1:0]   levels_low,
  input  logic [mled_pkg::CFG_DATA_W-1:0]   levels_high,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mled_pkg::PIXEL_W-1:0]      m_tdata,   // pixel_out
  output logic                              m_tlast,   // row_end
  output logic                              m_tuser    // frame_end
);

  import mled_pkg::*;

  localparam int DIST_W = PIXEL_W + 1;
  localparam int L1 = LEVEL_SLOTS / 2;
  localparam int L2 = LEVEL_SLOTS / 4;
  localparam int L3 = LEVEL_SLOTS / 8;

  logic             adv;
  logic             hazard;
  logic [COL_W-1:0] head_right;
  err_t             rd_above;
  err_t             rd_right;

  logic             b2_valid;
  item_t            b2_item;
  logic [COL_W-1:0] b2_col;
  logic             b3_valid;
  item_t            b3_item;
  logic [COL_W-1:0] b3_col;
  pixel_t           b3_sum;
  err_t             b3_right;
  logic             b4_valid;
  item_t            b4_item;
  logic [COL_W-1:0] b4_col;
  pixel_t           b4_sum;
  err_t             prev_above;
  err_t             left_err;

  pixel_t           u1;
  pixel_t           u2;
  pixel_t           u3;
  pixel_t           v4;
  err_t             err;

  logic [COUNT_REG_W-1:0]  n_eff;
  logic [2*CFG_DATA_W-1:0] level_bits;
  pixel_t                  lvl0  [LEVEL_SLOTS];
  logic [DIST_W-1:0]       dist0 [LEVEL_SLOTS];
  pixel_t                  lvl1  [L1];
  logic [DIST_W-1:0]       dist1 [L1];
  pixel_t                  lvl2  [L2];
  logic [DIST_W-1:0]       dist2 [L2];
  pixel_t                  lvl3  [L3];
  logic [DIST_W-1:0]       dist3 [L3];
  pixel_t                  best;

  assign adv        = !m_tvalid || m_tready;
  assign head_right = head_col + COL_W'(1);

  // an entry still to be written by an item in flight must not be read yet
  function automatic logic pending(input logic [COL_W-1:0] col,
                                   input logic v2, input logic [COL_W-1:0] c2,
                                   input logic v3, input logic [COL_W-1:0] c3,
                                   input logic v4_, input logic [COL_W-1:0] c4);
    return (v2 && c2 == col) || (v3 && c3 == col) || (v4_ && c4 == col);
  endfunction

  assign hazard = !head_item.first_row &&
                  (pending(head_col, b2_valid, b2_col, b3_valid, b3_col, b4_valid, b4_col) ||
                   (head_item.has_right &&
                    pending(head_right, b2_valid, b2_col, b3_valid, b3_col,
                            b4_valid, b4_col)));

  assign pop = adv && head_valid && !hazard;

  mled_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH),
    .ADDR_W(COL_W)
  ) u_error_store (
    .clk    (clk),
    .we     (adv && b4_valid),
    .waddr  (b4_col),
    .wdata  (err),
    .re     (pop),
    .raddr_a(head_col),
    .raddr_b(head_item.has_right ? head_right : head_col),
    .rdata_a(rd_above),
    .rdata_b(rd_right)
  );

  // above-left and above corrections
  always_comb begin
    u1 = b2_item.pixel;
    if (!b2_item.first_row && !b2_item.first_col) begin
      u1 = sat_add(u1, spread(prev_above, W_BELOW_RIGHT));
    end
    u2 = u1;
    if (!b2_item.first_row) begin
      u2 = sat_add(u1, spread(rd_above, W_BELOW));
    end
  end

  // above-right correction
  always_comb begin
    u3 = b3_sum;
    if (!b3_item.first_row && b3_item.has_right) begin
      u3 = sat_add(b3_sum, spread(b3_right, W_BELOW_LEFT));
    end
  end

  // left correction and nearest level
  assign v4 = b4_item.first_col ? b4_sum : sat_add(b4_sum, spread(left_err, W_RIGHT));

  always_comb begin
    if (level_count == '0) begin
      n_eff = COUNT_REG_W'(1);
    end else if (32'(level_count) > 32'(MAX_LEVELS)) begin
      n_eff = COUNT_REG_W'(MAX_LEVELS);
    end else begin
      n_eff = level_count;
    end
  end

  assign level_bits = {levels_high, levels_low};

  always_comb begin
    for (int k = 0; k < LEVEL_SLOTS; k++) begin
      lvl0[k] = level_bits[k*PIXEL_W +: PIXEL_W];
      if (COUNT_REG_W'(k) < n_eff) begin
        dist0[k] = (v4 >= lvl0[k]) ? {1'b0, v4 - lvl0[k]} : {1'b0, lvl0[k] - v4};
      end else begin
        dist0[k] = '1;
      end
    end
    for (int i = 0; i < L1; i++) begin
      if (dist0[2*i+1] < dist0[2*i]) begin
        dist1[i] = dist0[2*i+1];
        lvl1[i]  = lvl0[2*i+1];
      end else begin
        dist1[i] = dist0[2*i];
        lvl1[i]  = lvl0[2*i];
      end
    end
    for (int i = 0; i < L2; i++) begin
      if (dist1[2*i+1] < dist1[2*i]) begin
        dist2[i] = dist1[2*i+1];
        lvl2[i]  = lvl1[2*i+1];
      end else begin
        dist2[i] = dist1[2*i];
        lvl2[i]  = lvl1[2*i];
      end
    end
    for (int i = 0; i < L3; i++) begin
      if (dist2[2*i+1] < dist2[2*i]) begin
        dist3[i] = dist2[2*i+1];
        lvl3[i]  = lvl2[2*i+1];
      end else begin
        dist3[i] = dist2[2*i];
        lvl3[i]  = lvl2[2*i];
      end
    end
    best = (dist3[1] < dist3[0]) ? lvl3[1] : lvl3[0];
  end

  assign err = $signed({1'b0, v4}) - $signed({1'b0, best});

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      m_tvalid <= 1'b0;
      left_err <= '0;
    end else if (adv) begin
      b2_valid <= pop;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
      m_tvalid <= b4_valid;
      if (b4_valid) begin
        left_err <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_item  <= head_item;
      b2_col   <= head_col;
      b3_item  <= b2_item;
      b3_col   <= b2_col;
      b3_sum   <= u2;
      b3_right <= rd_right;
      b4_item  <= b3_item;
      b4_col   <= b3_col;
      b4_sum   <= u3;
      m_tdata  <= best;
      m_tlast  <= b4_item.row_end;
      m_tuser  <= b4_item.frame_end;
      if (b2_valid) begin
        prev_above <= rd_above;
      end
    end
  end

endmodule

### hdl/multilevel_error_diffusion_dither.sv
// Multilevel error diffusion dither: takes 8-bit grey pixels in raster order on the slave
// stream and returns, one for one, the nearest configured level on the master stream, with
// the quantisation error spread Floyd-Steinberg style. Throughput is one pixel per clock for
// rows of five or more pixels when m_tready does not stall the output; for narrower rows a
// pixel waits until the error store entries it reads have been written by the pixels ahead
// of it. Write the registers only while no pixel is in flight. m_tlast marks the last pixel
// of a row, m_tuser the last of a frame.
module multilevel_error_diffusion_dither #(
  parameter int MAX_WIDTH = mled_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mled_pkg::PIXEL_W-1:0]      s_tdata,   // pixel_in
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mled_pkg::PIXEL_W-1:0]      m_tdata,   // pixel_out
  output logic                              m_tlast,   // row_end
  output logic                              m_tuser,   // frame_end
  input  logic                              cfg_we,
  input  logic [mled_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mled_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import mled_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = COL_W + $bits(item_t);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COUNT_REG_W-1:0]  level_count;
  logic [CFG_DATA_W-1:0]   levels_low;
  logic [CFG_DATA_W-1:0]   levels_high;

  logic             push;
  item_t            front_item;
  logic [COL_W-1:0] front_col;
  logic             queue_full;
  logic             queue_empty;
  logic             pop;
  logic [ENTRY_W-1:0] head_entry;
  item_t            head_item;
  logic [COL_W-1:0] head_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
      level_count  <= RESET_LEVEL_COUNT;
      levels_low   <= RESET_LEVELS_LOW;
      levels_high  <= RESET_LEVELS_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        REG_LEVEL_COUNT:  level_count  <= cfg_data[COUNT_REG_W-1:0];
        REG_LEVELS_LOW:   levels_low   <= cfg_data;
        REG_LEVELS_HIGH:  levels_high  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mled_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .image_width (image_width),
    .image_height(image_height),
    .queue_full  (queue_full),
    .push        (push),
    .item        (front_item),
    .item_col    (front_col)
  );

  mled_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({front_col, front_item}),
    .pop      (pop),
    .head_data(head_entry),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  assign head_item = head_entry[$bits(item_t)-1:0];
  assign head_col  = head_entry[ENTRY_W-1:$bits(item_t)];

  mled_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!queue_empty),
    .head_item  (head_item),
    .head_col   (head_col),
    .pop        (pop),
    .level_count(level_count),
    .levels_low (levels_low),
    .levels_high(levels_high),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
